// ===== hdl/lts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time statistics package
// Shared constants and the command and status types that connect the
// controller to the datapath.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MAX_LAP_COUNT_DEF = 64;
  localparam int SECTORS_DEF       = 3;
  localparam int SECTOR_SLOTS      = 4;

  localparam int TIME_W      = 32;
  localparam int LAP_COUNT_W = 7;
  localparam int LAP_INDEX_W = 6;

  localparam logic [TIME_W-1:0] NO_TIME = '1;

  typedef struct packed {
    logic accum;     // fold the offered lap into the accumulators
    logic div_init;  // load the divider and the sector partial sums
    logic div_step;  // one restoring division step
    logic emit;      // latch the result and clear the session
  } lts_cmd_t;

  typedef struct packed {
    logic div_last;  // the divider is on its final step
  } lts_status_t;

endpackage

// ===== hdl/lts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time statistics controller
// Sequences the accumulation of each request and, on the final lap, the
// average division and the result emission.
// ----------------------------------------------------------------------------
module lts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last_lap,
  output logic                busy,
  output lts_pkg::lts_cmd_t   cmd,
  input  lts_pkg::lts_status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accum = 1'b1;
          if (in_last_lap) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time statistics datapath
// Session accumulators, a bit-serial restoring divider for the average and
// the result registers.
// ----------------------------------------------------------------------------
module lts_datapath #(
  parameter int MAX_LAP_COUNT = lts_pkg::MAX_LAP_COUNT_DEF,
  parameter int SECTORS       = lts_pkg::SECTORS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lts_pkg::lts_cmd_t                    cmd,
  output lts_pkg::lts_status_t                 status,
  input  logic [lts_pkg::TIME_W-1:0]           in_lap_time,
  input  logic [lts_pkg::TIME_W-1:0]           in_sector_time_0,
  input  logic [lts_pkg::TIME_W-1:0]           in_sector_time_1,
  input  logic [lts_pkg::TIME_W-1:0]           in_sector_time_2,
  input  logic [lts_pkg::TIME_W-1:0]           in_sector_time_3,
  output logic                                 out_valid,
  output logic [lts_pkg::LAP_COUNT_W-1:0]      out_lap_count,
  output logic [lts_pkg::TIME_W-1:0]           out_best_time,
  output logic [lts_pkg::LAP_INDEX_W-1:0]      out_best_lap_index,
  output logic [lts_pkg::TIME_W-1:0]           out_worst_time,
  output logic [lts_pkg::TIME_W-1:0]           out_average_time,
  output logic [lts_pkg::TIME_W-1:0]           out_ideal_time,
  output logic [lts_pkg::TIME_W-1:0]           out_best_sector_0,
  output logic [lts_pkg::TIME_W-1:0]           out_best_sector_1,
  output logic [lts_pkg::TIME_W-1:0]           out_best_sector_2,
  output logic [lts_pkg::TIME_W-1:0]           out_best_sector_3
);

  localparam int TW     = lts_pkg::TIME_W;
  localparam int SLOTS  = lts_pkg::SECTOR_SLOTS;
  localparam int CNT_W  = $clog2(MAX_LAP_COUNT + 1);
  localparam int SUM_W  = TW + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_LAP_COUNT);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SUM_W - 1);

  // Session accumulators.
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [SUM_W-1:0]  sum_r,   sum_nxt;
  logic [TW-1:0]     best_r,  best_nxt;
  logic [CNT_W-1:0]  idx_r,   idx_nxt;
  logic [TW-1:0]     worst_r, worst_nxt;
  logic [TW-1:0]     sb_r   [SLOTS];
  logic [TW-1:0]     sb_nxt [SLOTS];

  // Divider and partial sums.
  logic [CNT_W-1:0]  rem_r,  rem_nxt;
  logic [SUM_W-1:0]  quo_r,  quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TW-1:0]     s01_r,  s01_nxt;
  logic [TW-1:0]     s23_r,  s23_nxt;

  // Result registers.
  localparam int LAP_CNT_OUT = lts_pkg::LAP_COUNT_W;
  logic                   vld_r, vld_nxt;
  logic [LAP_CNT_OUT-1:0] ocnt_r, ocnt_nxt;
  logic [lts_pkg::LAP_INDEX_W-1:0] oidx_r, oidx_nxt;
  logic [TW-1:0] obest_r, obest_nxt;
  logic [TW-1:0] oworst_r, oworst_nxt;
  logic [TW-1:0] oavg_r, oavg_nxt;
  logic [TW-1:0] oideal_r, oideal_nxt;
  logic [TW-1:0] osec_r   [SLOTS];
  logic [TW-1:0] osec_nxt [SLOTS];

  logic [TW-1:0]      sec_in [SLOTS];
  logic [TW-1:0]      bm     [SLOTS];
  logic               complete;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;
  logic [CNT_W+lts_pkg::LAP_COUNT_W-1:0] cnt_ext;
  logic [CNT_W+lts_pkg::LAP_INDEX_W-1:0] idx_ext;

  assign sec_in[0] = in_sector_time_0;
  assign sec_in[1] = in_sector_time_1;
  assign sec_in[2] = in_sector_time_2;
  assign sec_in[3] = in_sector_time_3;

  // Best sector times as reported: zero for unused sectors and for sectors
  // that never saw a time.
  always_comb begin
    complete = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      if (s < SECTORS && sb_r[s] != lts_pkg::NO_TIME) begin
        bm[s] = sb_r[s];
      end else begin
        bm[s] = '0;
      end
      if (s < SECTORS && sb_r[s] == lts_pkg::NO_TIME) begin
        complete = 1'b0;
      end
    end
  end

  // The remainder stays below the divisor, so one extra bit holds the trial.
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, cnt_r};
  assign ge    = (trial >= {1'b0, cnt_r});

  assign cnt_ext = {{lts_pkg::LAP_COUNT_W{1'b0}}, cnt_r};
  assign idx_ext = {{lts_pkg::LAP_INDEX_W{1'b0}}, idx_r};

  assign status.div_last = (step_r == '0);

  always_comb begin
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    best_nxt   = best_r;
    idx_nxt    = idx_r;
    worst_nxt  = worst_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    s01_nxt    = s01_r;
    s23_nxt    = s23_r;
    ocnt_nxt   = ocnt_r;
    oidx_nxt   = oidx_r;
    obest_nxt  = obest_r;
    oworst_nxt = oworst_r;
    oavg_nxt   = oavg_r;
    oideal_nxt = oideal_r;
    for (int s = 0; s < SLOTS; s++) begin
      sb_nxt[s]   = sb_r[s];
      osec_nxt[s] = osec_r[s];
    end
    vld_nxt = cmd.emit;

    // Laps past a full session are ignored.
    if (cmd.accum && cnt_r != FULL_COUNT) begin
      sum_nxt = sum_r + {{CNT_W{1'b0}}, in_lap_time};
      if (in_lap_time < best_r) begin
        best_nxt = in_lap_time;
        idx_nxt  = cnt_r;
      end
      if (in_lap_time > worst_r) begin
        worst_nxt = in_lap_time;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (s < SECTORS && sec_in[s] != '0 && sec_in[s] < sb_r[s]) begin
          sb_nxt[s] = sec_in[s];
        end
      end
      cnt_nxt = cnt_r + 1'b1;
    end

    if (cmd.div_init) begin
      rem_nxt  = '0;
      quo_nxt  = sum_r;
      step_nxt = LAST_STEP;
      s01_nxt  = bm[0] + bm[1];
      s23_nxt  = bm[2] + bm[3];
    end

    if (cmd.div_step) begin
      rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
    end

    if (cmd.emit) begin
      ocnt_nxt   = cnt_ext[lts_pkg::LAP_COUNT_W-1:0];
      oidx_nxt   = idx_ext[lts_pkg::LAP_INDEX_W-1:0];
      obest_nxt  = best_r;
      oworst_nxt = worst_r;
      oavg_nxt   = (cnt_r == '0) ? '0 : quo_r[TW-1:0];
      oideal_nxt = complete ? (s01_r + s23_r) : '0;
      for (int s = 0; s < SLOTS; s++) begin
        osec_nxt[s] = bm[s];
      end
      cnt_nxt   = '0;
      sum_nxt   = '0;
      best_nxt  = lts_pkg::NO_TIME;
      idx_nxt   = '0;
      worst_nxt = '0;
      for (int s = 0; s < SLOTS; s++) begin
        sb_nxt[s] = lts_pkg::NO_TIME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      best_r  <= lts_pkg::NO_TIME;
      idx_r   <= '0;
      worst_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        sb_r[s] <= lts_pkg::NO_TIME;
      end
      vld_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      best_r  <= best_nxt;
      idx_r   <= idx_nxt;
      worst_r <= worst_nxt;
      for (int s = 0; s < SLOTS; s++) begin
        sb_r[s] <= sb_nxt[s];
      end
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    step_r   <= step_nxt;
    s01_r    <= s01_nxt;
    s23_r    <= s23_nxt;
    ocnt_r   <= ocnt_nxt;
    oidx_r   <= oidx_nxt;
    obest_r  <= obest_nxt;
    oworst_r <= oworst_nxt;
    oavg_r   <= oavg_nxt;
    oideal_r <= oideal_nxt;
    for (int s = 0; s < SLOTS; s++) begin
      osec_r[s] <= osec_nxt[s];
    end
  end

  assign out_valid          = vld_r;
  assign out_lap_count      = ocnt_r;
  assign out_best_time      = obest_r;
  assign out_best_lap_index = oidx_r;
  assign out_worst_time     = oworst_r;
  assign out_average_time   = oavg_r;
  assign out_ideal_time     = oideal_r;
  assign out_best_sector_0  = osec_r[0];
  assign out_best_sector_1  = osec_r[1];
  assign out_best_sector_2  = osec_r[2];
  assign out_best_sector_3  = osec_r[3];

endmodule

// ===== hdl/lap_time_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time statistics unit
// A lap that is not the last is accumulated with busy left low; the next may
// follow in the next cycle. The last lap holds busy high while the session
// sum is divided bit-serially over SUM_W = 32 + clog2(MAX_LAP_COUNT + 1)
// bits (39 at the defaults); the result strobes in the cycle busy falls.
// The receiver cannot stall. Synchronous active-low reset clears the session.
// ----------------------------------------------------------------------------
module lap_time_statistics_unit #(
  parameter int MAX_LAP_COUNT = lts_pkg::MAX_LAP_COUNT_DEF,
  parameter int SECTORS       = lts_pkg::SECTORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lts_pkg::TIME_W-1:0]       in_lap_time,
  input  logic [lts_pkg::TIME_W-1:0]       in_sector_time_0,
  input  logic [lts_pkg::TIME_W-1:0]       in_sector_time_1,
  input  logic [lts_pkg::TIME_W-1:0]       in_sector_time_2,
  input  logic [lts_pkg::TIME_W-1:0]       in_sector_time_3,
  input  logic                             in_last_lap,
  output logic                             out_valid,
  output logic [lts_pkg::LAP_COUNT_W-1:0]  out_lap_count,
  output logic [lts_pkg::TIME_W-1:0]       out_best_time,
  output logic [lts_pkg::LAP_INDEX_W-1:0]  out_best_lap_index,
  output logic [lts_pkg::TIME_W-1:0]       out_worst_time,
  output logic [lts_pkg::TIME_W-1:0]       out_average_time,
  output logic [lts_pkg::TIME_W-1:0]       out_ideal_time,
  output logic [lts_pkg::TIME_W-1:0]       out_best_sector_0,
  output logic [lts_pkg::TIME_W-1:0]       out_best_sector_1,
  output logic [lts_pkg::TIME_W-1:0]       out_best_sector_2,
  output logic [lts_pkg::TIME_W-1:0]       out_best_sector_3
);

  lts_pkg::lts_cmd_t    cmd;
  lts_pkg::lts_status_t status;

  lts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_lap (in_last_lap),
    .busy        (busy),
    .cmd         (cmd),
    .status      (status)
  );

  lts_datapath #(
    .MAX_LAP_COUNT (MAX_LAP_COUNT),
    .SECTORS       (SECTORS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_lap_time        (in_lap_time),
    .in_sector_time_0   (in_sector_time_0),
    .in_sector_time_1   (in_sector_time_1),
    .in_sector_time_2   (in_sector_time_2),
    .in_sector_time_3   (in_sector_time_3),
    .out_valid          (out_valid),
    .out_lap_count      (out_lap_count),
    .out_best_time      (out_best_time),
    .out_best_lap_index (out_best_lap_index),
    .out_worst_time     (out_worst_time),
    .out_average_time   (out_average_time),
    .out_ideal_time     (out_ideal_time),
    .out_best_sector_0  (out_best_sector_0),
    .out_best_sector_1  (out_best_sector_1),
    .out_best_sector_2  (out_best_sector_2),
    .out_best_sector_3  (out_best_sector_3)
  );

endmodule

// ===== hdl/lts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lap time statistics checker
// Port-level properties of the request and result timing, bound to the
// top level.
// ----------------------------------------------------------------------------
module lts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_last_lap,
  input logic                        out_valid,
  input logic [lts_pkg::TIME_W-1:0]  out_best_time,
  input logic [lts_pkg::TIME_W-1:0]  out_worst_time
);

  // A request that is not the last lap never blocks the next one.
  a_plain_lap_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_lap |=> !busy)
    else $error("busy rose after a plain lap");

  // The last lap always starts the result computation.
  a_last_lap_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_lap |=> busy)
    else $error("last lap did not start the result computation");

  // The result comes exactly when the computation ends.
  a_result_on_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

  a_result_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe longer than one cycle or while busy");

  // Every session holds at least one lap, so best never exceeds worst.
  a_best_not_above_worst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_time <= out_worst_time)
    else $error("best lap time above worst lap time");

endmodule

bind lap_time_statistics_unit lts_checker u_lts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_lap    (in_last_lap),
  .out_valid      (out_valid),
  .out_best_time  (out_best_time),
  .out_worst_time (out_worst_time)
);
